// ===== rtl/core/mcss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_pkg: shared definitions of the MIDI clocked step sequencer
// Field widths, MIDI codes, event and register codes, default sizes, and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcss_pkg;

    // Default sizes of the sequencer.
    localparam int STEP_COUNT      = 16;
    localparam int TRACK_COUNT     = 8;
    localparam int CLOCKS_PER_STEP = 6;
    localparam int BASE_NOTE       = 36;

    // Field widths of the event and result items.
    localparam int OPCODE_W = 2;
    localparam int LEN_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int TS_W     = 48;
    localparam int PW_W     = 47;
    localparam int NOTE_W   = 6;
    localparam int STEPO_W  = 4;
    localparam int SRC_W    = 2;
    localparam int CHAN_W   = 4;

    // Event codes.
    localparam logic [OPCODE_W-1:0] OP_UART = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_USB  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_SYNC = 2'd3;

    // Clock source selections.
    localparam logic [SRC_W-1:0] SRC_TIMER = 2'd0;
    localparam logic [SRC_W-1:0] SRC_SYNC  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_UART  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_USB   = 2'd3;

    // MIDI message codes.
    localparam logic [LEN_W-1:0]  LEN_SHORT    = 2'd1;
    localparam logic [LEN_W-1:0]  LEN_FULL     = 2'd3;
    localparam logic [BYTE_W-1:0] STATUS_CLOCK = 8'hF8;
    localparam logic [3:0]        NOTE_ON_HI   = 4'h9;

    // Result kinds.
    localparam logic KIND_CLOCK = 1'b0;
    localparam logic KIND_NOTE  = 1'b1;

    // Configuration register indexes (address bit 2).
    localparam logic REG_CLOCK_SOURCE = 1'b0;
    localparam logic REG_OUT_CHANNEL  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic clock_upd;
        logic mem_wr;
        logic clk_out;
        logic trk_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic is_clock;
        logic is_write;
        logic advance;
        logic out_free;
        logic trk_last;
    } sts_t;

endpackage

// ===== rtl/core/mcss_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss channel interfaces
// Valid/ready channels that carry sequencer events in and results out.
// ----------------------------------------------------------------------------
interface mcss_event_if;
    logic                             valid;
    logic                             ready;
    logic [mcss_pkg::OPCODE_W-1:0]    opcode;
    logic [mcss_pkg::LEN_W-1:0]       msg_length;
    logic [mcss_pkg::BYTE_W-1:0]      status_byte;
    logic [mcss_pkg::BYTE_W-1:0]      data_one;
    logic [mcss_pkg::BYTE_W-1:0]      data_two;
    logic                             sync_rise;
    logic [mcss_pkg::TS_W-1:0]        timestamp_us;

    modport source (
        output valid, opcode, msg_length, status_byte, data_one, data_two,
               sync_rise, timestamp_us,
        input  ready
    );
    modport sink (
        input  valid, opcode, msg_length, status_byte, data_one, data_two,
               sync_rise, timestamp_us,
        output ready
    );
endinterface

interface mcss_result_if;
    logic                             valid;
    logic                             ready;
    logic                             result_kind;
    logic                             gate_pulse;
    logic [mcss_pkg::PW_W-1:0]        pulse_width_us;
    logic [mcss_pkg::NOTE_W-1:0]      note_number;
    logic [mcss_pkg::BYTE_W-1:0]      velocity_out;
    logic                             trigger_pulse;
    logic [mcss_pkg::STEPO_W-1:0]     step_index;
    logic                             last;

    modport source (
        output valid, result_kind, gate_pulse, pulse_width_us, note_number,
               velocity_out, trigger_pulse, step_index, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, gate_pulse, pulse_width_us, note_number,
               velocity_out, trigger_pulse, step_index, last,
        output ready
    );
endinterface

// ===== rtl/core/mcss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_ctrl: sequencer controller
// State machine that runs the clearing pass, takes events, and sequences
// the clock result and the per-track note results through the datapath.
// ----------------------------------------------------------------------------
module mcss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mcss_pkg::sts_t       sts,
    output mcss_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_CLKOUT = 3'd3;
    localparam logic [2:0] S_TRK    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_clock)
                begin
                    cmd.clock_upd = 1'b1;
                    state_next    = S_CLKOUT;
                end
                else
                begin
                    cmd.mem_wr = sts.is_write;
                    state_next = S_IDLE;
                end
            end
            S_CLKOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.clk_out = 1'b1;
                    state_next  = sts.advance ? S_TRK : S_IDLE;
                end
            end
            S_TRK:
            begin
                if (sts.out_free)
                begin
                    cmd.trk_out = 1'b1;
                    if (sts.trk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted event is always decoded in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_EXEC)
        else $error("accepted event not decoded");

    // Results are only loaded when the output register can take them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clk_out || cmd.trk_out) |-> sts.out_free)
        else $error("result loaded into a full output register");

    // After the last track result the controller returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRK && sts.out_free && sts.trk_last) |=> state_reg == S_IDLE)
        else $error("track sequence did not end after the last track");
`endif

endmodule

// ===== rtl/core/mcss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_dp: sequencer datapath
// Event register and decode, pattern memory, clock phase, step counter,
// period measurement and the result output register.
// ----------------------------------------------------------------------------
module mcss_dp #(
    parameter int STEP_COUNT      = mcss_pkg::STEP_COUNT,
    parameter int TRACK_COUNT     = mcss_pkg::TRACK_COUNT,
    parameter int CLOCKS_PER_STEP = mcss_pkg::CLOCKS_PER_STEP,
    parameter int BASE_NOTE       = mcss_pkg::BASE_NOTE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcss_pkg::cmd_t                    cmd,
    output mcss_pkg::sts_t                    sts,
    input  logic [mcss_pkg::SRC_W-1:0]        clock_source,
    input  logic [mcss_pkg::OPCODE_W-1:0]     opcode,
    input  logic [mcss_pkg::LEN_W-1:0]        msg_length,
    input  logic [mcss_pkg::BYTE_W-1:0]       status_byte,
    input  logic [mcss_pkg::BYTE_W-1:0]       data_one,
    input  logic [mcss_pkg::BYTE_W-1:0]       data_two,
    input  logic                              sync_rise,
    input  logic [mcss_pkg::TS_W-1:0]         timestamp_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              result_kind,
    output logic                              gate_pulse,
    output logic [mcss_pkg::PW_W-1:0]         pulse_width_us,
    output logic [mcss_pkg::NOTE_W-1:0]       note_number,
    output logic [mcss_pkg::BYTE_W-1:0]       velocity_out,
    output logic                              trigger_pulse,
    output logic [mcss_pkg::STEPO_W-1:0]      step_index,
    output logic                              last
);

    localparam int STEP_W  = $clog2(STEP_COUNT);
    localparam int TRACK_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int PHASE_W = (CLOCKS_PER_STEP > 1) ? $clog2(CLOCKS_PER_STEP) : 1;
    localparam int ADDR_W  = TRACK_W + STEP_W;
    localparam int DEPTH   = 1 << ADDR_W;

    localparam logic [mcss_pkg::BYTE_W:0] STEP_LIM  = (mcss_pkg::BYTE_W + 1)'(STEP_COUNT);
    localparam logic [3:0]                TRACK_LIM = 4'(TRACK_COUNT);
    localparam logic [PHASE_W:0]          PHASE_LIM = (PHASE_W + 1)'(CLOCKS_PER_STEP);
    localparam logic [STEP_W-1:0]         STEP_MAX  = STEP_W'(STEP_COUNT - 1);
    localparam logic [TRACK_W-1:0]        TRACK_MAX = TRACK_W'(TRACK_COUNT - 1);
    localparam logic [6:0]                NOTE_BASE = 7'(BASE_NOTE);

    // Captured event.
    logic [mcss_pkg::OPCODE_W-1:0] op_reg;
    logic [mcss_pkg::LEN_W-1:0]    len_reg;
    logic [mcss_pkg::BYTE_W-1:0]   stat_reg;
    logic [mcss_pkg::BYTE_W-1:0]   d1_reg;
    logic [mcss_pkg::BYTE_W-1:0]   d2_reg;
    logic                          sync_reg;
    logic [mcss_pkg::TS_W-1:0]     ts_reg;

    // Sequencer state.
    logic [PHASE_W-1:0]            phase_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [mcss_pkg::TS_W-1:0]     last_time_reg;
    logic [mcss_pkg::PW_W-1:0]     width_reg;
    logic                          advance_reg;
    logic [TRACK_W-1:0]            trk_reg;
    logic [ADDR_W-1:0]             clr_reg;

    // Pattern memory.
    logic [mcss_pkg::BYTE_W-1:0]   mem [DEPTH];
    logic [mcss_pkg::BYTE_W-1:0]   rdata_reg;

    // Output register.
    logic                          ovalid_reg;
    logic                          okind_reg;
    logic                          ogate_reg;
    logic [mcss_pkg::PW_W-1:0]     owidth_reg;
    logic [mcss_pkg::NOTE_W-1:0]   onote_reg;
    logic [mcss_pkg::BYTE_W-1:0]   ovel_reg;
    logic                          otrig_reg;
    logic [mcss_pkg::STEPO_W-1:0]  ostep_reg;
    logic                          olast_reg;

    logic                          short_clock;
    logic                          is_clock;
    logic                          is_write;
    logic [2:0]                    chan_trk;
    logic [mcss_pkg::TS_W-1:0]     period;
    logic [PHASE_W:0]              phase_inc;
    logic                          advance;
    logic                          we;
    logic [ADDR_W-1:0]             waddr;
    logic [mcss_pkg::BYTE_W-1:0]   wdata;
    logic                          re;
    logic [TRACK_W-1:0]            rtrk;
    logic [ADDR_W-1:0]             raddr;
    logic [6:0]                    note_sum;
    logic [STEP_W+3:0]             step_ext;

    // Event register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            len_reg  <= msg_length;
            stat_reg <= status_byte;
            d1_reg   <= data_one;
            d2_reg   <= data_two;
            sync_reg <= sync_rise;
            ts_reg   <= timestamp_us;
        end
    end

    // Event decode: clocks from the selected source and pattern writes.
    always_comb
    begin
        short_clock = (len_reg == mcss_pkg::LEN_SHORT) && (stat_reg == mcss_pkg::STATUS_CLOCK);
        case (op_reg)
            mcss_pkg::OP_UART: is_clock = short_clock && (clock_source == mcss_pkg::SRC_UART);
            mcss_pkg::OP_USB:  is_clock = short_clock && (clock_source == mcss_pkg::SRC_USB);
            mcss_pkg::OP_TICK: is_clock = (clock_source == mcss_pkg::SRC_TIMER);
            mcss_pkg::OP_SYNC: is_clock = sync_reg && (clock_source == mcss_pkg::SRC_SYNC);
            default:           is_clock = 1'b0;
        endcase
        chan_trk = stat_reg[2:0];
        is_write = ((op_reg == mcss_pkg::OP_UART) || (op_reg == mcss_pkg::OP_USB))
                   && (len_reg == mcss_pkg::LEN_FULL)
                   && (stat_reg[7:4] == mcss_pkg::NOTE_ON_HI)
                   && stat_reg[3]
                   && ({1'b0, chan_trk} < TRACK_LIM)
                   && ({1'b0, d1_reg} < STEP_LIM);
    end

    // Period since the previous clock, phase advance.
    assign period    = ts_reg - last_time_reg;
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign advance   = (phase_inc >= PHASE_LIM);

    // Clock state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            step_reg      <= '0;
            last_time_reg <= '0;
            advance_reg   <= 1'b0;
            trk_reg       <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            if (cmd.clock_upd)
            begin
                last_time_reg <= ts_reg;
                advance_reg   <= advance;
                trk_reg       <= '0;
                if (advance)
                begin
                    phase_reg <= '0;
                    step_reg  <= (step_reg == STEP_MAX) ? '0 : step_reg + 1'b1;
                end
                else
                begin
                    phase_reg <= phase_inc[PHASE_W-1:0];
                end
            end
            if (cmd.trk_out)
            begin
                trk_reg <= trk_reg + 1'b1;
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Half-period pulse width.
    always_ff @(posedge clk)
    begin
        if (cmd.clock_upd)
        begin
            width_reg <= period[mcss_pkg::TS_W-1:1];
        end
    end

    // Memory port selection: clearing pass or note-on write; track reads.
    assign we    = cmd.clear_wr || cmd.mem_wr;
    assign waddr = cmd.clear_wr ? clr_reg
                                : {chan_trk[TRACK_W-1:0], d1_reg[STEP_W-1:0]};
    assign wdata = cmd.clear_wr ? '0 : d2_reg;
    assign re    = cmd.clk_out || cmd.trk_out;
    assign rtrk  = cmd.clk_out ? '0 : trk_reg + 1'b1;
    assign raddr = {rtrk, step_reg};

    // Pattern memory with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign note_sum = NOTE_BASE + 7'(trk_reg);
    assign step_ext = {4'b0, step_reg};

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.clk_out || cmd.trk_out)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // Output payload: clock result or track note result.
    always_ff @(posedge clk)
    begin
        if (cmd.clk_out)
        begin
            okind_reg  <= mcss_pkg::KIND_CLOCK;
            ogate_reg  <= advance_reg;
            owidth_reg <= width_reg;
            onote_reg  <= '0;
            ovel_reg   <= '0;
            otrig_reg  <= 1'b0;
            ostep_reg  <= step_ext[3:0];
            olast_reg  <= !advance_reg;
        end
        else if (cmd.trk_out)
        begin
            okind_reg  <= mcss_pkg::KIND_NOTE;
            ogate_reg  <= 1'b0;
            owidth_reg <= width_reg;
            onote_reg  <= note_sum[mcss_pkg::NOTE_W-1:0];
            ovel_reg   <= rdata_reg;
            otrig_reg  <= (rdata_reg != '0);
            ostep_reg  <= step_ext[3:0];
            olast_reg  <= (trk_reg == TRACK_MAX);
        end
    end

    // Status to the controller.
    assign sts.clear_done = (clr_reg == '1);
    assign sts.is_clock   = is_clock;
    assign sts.is_write   = is_write;
    assign sts.advance    = advance_reg;
    assign sts.out_free   = !ovalid_reg || out_ready;
    assign sts.trk_last   = (trk_reg == TRACK_MAX);

    assign out_valid      = ovalid_reg;
    assign result_kind    = okind_reg;
    assign gate_pulse     = ogate_reg;
    assign pulse_width_us = owidth_reg;
    assign note_number    = onote_reg;
    assign velocity_out   = ovel_reg;
    assign trigger_pulse  = otrig_reg;
    assign step_index     = ostep_reg;
    assign last           = olast_reg;

endmodule

// ===== rtl/core/midi_clocked_step_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clocked_step_sequencer_top: MIDI clocked drum step sequencer
// Configuration registers, APB port, controller and datapath.
// ----------------------------------------------------------------------------
// After reset the block clears its pattern memory, one entry a cycle, through all
// 2^(TRACK_BITS + STEP_BITS) entries, where TRACK_BITS is ceil(log2(TRACK_COUNT))
// but at least 1 and STEP_BITS is ceil(log2(STEP_COUNT)) (128 with the default
// sizes); events are held off during that pass while APB writes are taken.
// Events are handled one at a time: each is captured and then decoded. A note-on
// write or an ignored event then frees the block; a clock event updates the clock
// state and gives one result, and on a step advance it gives 1 + TRACK_COUNT
// results, one a cycle while the output register is free, since the tracks are
// read one after another through the single read port of the pattern memory.
// Results wait in an output register, so a stalled result only holds the
// block once it has a new result to give.
// ----------------------------------------------------------------------------
module midi_clocked_step_sequencer_top #(
    parameter int STEP_COUNT      = mcss_pkg::STEP_COUNT,
    parameter int TRACK_COUNT     = mcss_pkg::TRACK_COUNT,
    parameter int CLOCKS_PER_STEP = mcss_pkg::CLOCKS_PER_STEP,
    parameter int BASE_NOTE       = mcss_pkg::BASE_NOTE
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    mcss_event_if.sink           event_ch,
    mcss_result_if.source        result_ch
);

    logic [mcss_pkg::SRC_W-1:0]  clock_source_reg;
    logic [mcss_pkg::CHAN_W-1:0] out_channel_reg;
    logic                        cfg_wr;
    logic                        in_ready;
    mcss_pkg::cmd_t              cmd;
    mcss_pkg::sts_t              sts;

    // Configuration writes.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_source_reg <= mcss_pkg::SRC_TIMER;
            out_channel_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                mcss_pkg::REG_CLOCK_SOURCE: clock_source_reg <= pwdata[mcss_pkg::SRC_W-1:0];
                mcss_pkg::REG_OUT_CHANNEL:  out_channel_reg  <= pwdata[mcss_pkg::CHAN_W-1:0];
                default:                    clock_source_reg <= clock_source_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            mcss_pkg::REG_CLOCK_SOURCE: prdata = {30'b0, clock_source_reg};
            mcss_pkg::REG_OUT_CHANNEL:  prdata = {28'b0, out_channel_reg};
            default:                    prdata = '0;
        endcase
    end

    assign event_ch.ready = in_ready;

    // Controller.
    mcss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (event_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    mcss_dp #(
        .STEP_COUNT      (STEP_COUNT),
        .TRACK_COUNT     (TRACK_COUNT),
        .CLOCKS_PER_STEP (CLOCKS_PER_STEP),
        .BASE_NOTE       (BASE_NOTE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .clock_source   (clock_source_reg),
        .opcode         (event_ch.opcode),
        .msg_length     (event_ch.msg_length),
        .status_byte    (event_ch.status_byte),
        .data_one       (event_ch.data_one),
        .data_two       (event_ch.data_two),
        .sync_rise      (event_ch.sync_rise),
        .timestamp_us   (event_ch.timestamp_us),
        .out_valid      (result_ch.valid),
        .out_ready      (result_ch.ready),
        .result_kind    (result_ch.result_kind),
        .gate_pulse     (result_ch.gate_pulse),
        .pulse_width_us (result_ch.pulse_width_us),
        .note_number    (result_ch.note_number),
        .velocity_out   (result_ch.velocity_out),
        .trigger_pulse  (result_ch.trigger_pulse),
        .step_index     (result_ch.step_index),
        .last           (result_ch.last)
    );

endmodule
